// ===== design/heatmap_value_to_rgb_assert.svh =====
// Assertion macros shared by the heat-map colour mapper modules.
// No dependencies; included by the modules that carry assertions.
`ifndef HEATMAP_VALUE_TO_RGB_ASSERT_SVH
`define HEATMAP_VALUE_TO_RGB_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HMV_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define HMV_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/hmv_pkg.sv =====
// Shared types and constants for the heat-map colour mapper.
// No dependencies.
`default_nettype none

package hmv_pkg;

   // hue sectors, in units of 60 degrees
   localparam logic [2:0] SEC_RED    = 3'd0;
   localparam logic [2:0] SEC_YELLOW = 3'd1;
   localparam logic [2:0] SEC_GREEN  = 3'd2;
   localparam logic [2:0] SEC_CYAN   = 3'd3;
   localparam logic [2:0] SEC_BLUE   = 3'd4;

   localparam int FIT_SPAN    = 25;    // one sector in fitness mode, in units of one
   localparam int FIT_CLAMP   = 50;
   localparam int CHAN_SCALE  = 510;   // twice 255, for round half up
   localparam int RECIP_25    = 5243;  // ceil(2^17 / 25)
   localparam int RECIP_SHIFT = 17;
   localparam int UNUM_W      = 13;    // scaled channel numerator, at most 6387
   localparam int PROD_W      = 26;

   localparam logic [7:0] BYTE_MAX = 8'd255;

   typedef struct packed {
      logic [2:0]        sector;
      logic [UNUM_W-1:0] rise_num;
      logic [UNUM_W-1:0] fall_num;
      logic              fit;
      logic              bad;
   } scaled_type;

   typedef struct packed {
      logic [2:0] sector;
      logic [7:0] rise;
      logic [7:0] fall;
      logic       bad;
   } bytes_type;

endpackage

`default_nettype wire

// ===== design/hmv_channels.sv =====
// Handshake channels of the heat-map colour mapper: request, response, CSR.
// No dependencies.
`default_nettype none

interface hmv_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] sample_value;
   modport source (output valid, output sample_value, input ready);
   modport sink   (input valid, input sample_value, output ready);
endinterface

interface hmv_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       out_of_range;
   modport source (output valid, output red, output green, output blue,
                   output out_of_range, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input out_of_range, output ready);
endinterface

interface hmv_csr_if;
   logic valid;
   logic ready;
   logic fitness_mode;
   modport source (output valid, output fitness_mode, input ready);
   modport sink   (input valid, input fitness_mode, output ready);
endinterface

`default_nettype wire

// ===== design/hmv_front.sv =====
// Range check, hue sector split and channel numerator scaling: three stages.
// Depends on hmv_pkg and heatmap_value_to_rgb_assert.svh.
`default_nettype none
`include "heatmap_value_to_rgb_assert.svh"

module hmv_front #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic [31:0]        sample_value,
   input  wire logic               fitness_mode,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output hmv_pkg::scaled_type     out_data
);

   localparam int NW = FRAC_BITS + 7;   // hue numerator, up to 100 * one
   localparam int RW = FRAC_BITS + 5;   // remainder and denominator, below 32 * one
   localparam int XW = FRAC_BITS + 14;  // 510 * rem + den
   localparam logic [31:0] ONE_W   = 32'd1 << FRAC_BITS;
   localparam logic [31:0] CLAMP_W = 32'(hmv_pkg::FIT_CLAMP) << FRAC_BITS;
   localparam logic [RW-1:0] ONE_R  = RW'(1) << FRAC_BITS;
   localparam logic [RW-1:0] SPAN_R = RW'(hmv_pkg::FIT_SPAN) << FRAC_BITS;

   logic en1, en2, en3;
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;

   // stage 1
   logic [NW-1:0] n1_ff, n1_in;
   logic          fit1_ff, bad1_ff, bad1_in;
   logic [31:0]   diff, zc;

   // stage 2
   logic [6:0]    q;
   logic [6:0]    q_base;
   logic [2:0]    sec_fit, sec2_in, sec2_ff;
   logic [RW-1:0] rem, den, rise2_ff, fall2_ff, den2_ff;
   logic          fit2_ff, bad2_ff;

   // stage 3
   logic [XW-1:0]       x_rise, x_fall;
   hmv_pkg::scaled_type s3_in, s3_ff;

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   assign v1_in = en1 ? in_valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;

   // Negative values are caught by the sign bit, so unsigned compares suffice
   always_comb begin
      bad1_in = sample_value[31] || (!fitness_mode && (sample_value > ONE_W));
      diff    = ONE_W - sample_value;
      zc      = (sample_value > CLAMP_W) ? CLAMP_W : sample_value;
      n1_in   = fitness_mode ? {zc[NW-2:0], 1'b0} : {diff[NW-3:0], 2'b00};
   end

   // Fitness sectors are 25 * one wide, so the integer part decides the sector
   assign q = n1_ff[NW-1:FRAC_BITS];

   always_comb begin
      if (q >= 7'(4 * hmv_pkg::FIT_SPAN)) begin
         sec_fit = hmv_pkg::SEC_BLUE;
         q_base  = 7'(4 * hmv_pkg::FIT_SPAN);
      end else if (q >= 7'(3 * hmv_pkg::FIT_SPAN)) begin
         sec_fit = hmv_pkg::SEC_CYAN;
         q_base  = 7'(3 * hmv_pkg::FIT_SPAN);
      end else if (q >= 7'(2 * hmv_pkg::FIT_SPAN)) begin
         sec_fit = hmv_pkg::SEC_GREEN;
         q_base  = 7'(2 * hmv_pkg::FIT_SPAN);
      end else if (q >= 7'(hmv_pkg::FIT_SPAN)) begin
         sec_fit = hmv_pkg::SEC_YELLOW;
         q_base  = 7'(hmv_pkg::FIT_SPAN);
      end else begin
         sec_fit = hmv_pkg::SEC_RED;
         q_base  = 7'd0;
      end
      if (fit1_ff) begin
         sec2_in = sec_fit;
         rem     = {5'(q - q_base), n1_ff[FRAC_BITS-1:0]};
         den     = SPAN_R;
      end else begin
         sec2_in = q[2:0];
         rem     = {5'd0, n1_ff[FRAC_BITS-1:0]};
         den     = ONE_R;
      end
   end

   // byte = (510 * a + den) / (2 * den); the power-of-two part of 2 * den is
   // taken here, the factor 25 of fitness mode in the next unit
   always_comb begin
      x_rise = XW'(rise2_ff) * XW'(hmv_pkg::CHAN_SCALE) + XW'(den2_ff);
      x_fall = XW'(fall2_ff) * XW'(hmv_pkg::CHAN_SCALE) + XW'(den2_ff);
      s3_in.sector   = sec2_ff;
      s3_in.rise_num = x_rise[FRAC_BITS+1 +: hmv_pkg::UNUM_W];
      s3_in.fall_num = x_fall[FRAC_BITS+1 +: hmv_pkg::UNUM_W];
      s3_in.fit      = fit2_ff;
      s3_in.bad      = bad2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
      if (en1 && in_valid) begin
         n1_ff   <= n1_in;
         fit1_ff <= fitness_mode;
         bad1_ff <= bad1_in;
      end
      if (en2 && v1_ff) begin
         sec2_ff  <= sec2_in;
         rise2_ff <= rem;
         fall2_ff <= den - rem;
         den2_ff  <= den;
         fit2_ff  <= fit1_ff;
         bad2_ff  <= bad1_ff;
      end
      if (en3 && v2_ff) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = s3_ff;

   `HMV_ASSERT_NXT(a_front_hold, clock, reset, v3_ff && !out_ready, v3_ff,
      "front stage dropped a stalled request")
   `HMV_ASSERT_IMP(a_front_unit_bytes, clock, reset, v3_ff && !s3_ff.fit,
      (s3_ff.rise_num <= 13'(255)) && (s3_ff.fall_num <= 13'(255)),
      "unit-range channel numerator exceeds a byte")

endmodule

`default_nettype wire

// ===== design/hmv_scale.sv =====
// Channel byte stage: divides the fitness-mode numerators by 25 through a
// reciprocal multiply. Depends on hmv_pkg.
`default_nettype none

module hmv_scale (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire hmv_pkg::scaled_type in_data,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output hmv_pkg::bytes_type       out_data
);

   logic                         en;
   logic                         v_ff, v_in;
   logic [hmv_pkg::PROD_W-1:0]   prod_rise, prod_fall;
   hmv_pkg::bytes_type           b_in, b_ff;

   assign en       = !v_ff || out_ready;
   assign in_ready = en;
   assign v_in     = en ? in_valid : v_ff;

   // numerators stay at or below 6387, where the reciprocal is exact
   always_comb begin
      prod_rise = hmv_pkg::PROD_W'(in_data.rise_num)
                * hmv_pkg::PROD_W'(hmv_pkg::RECIP_25);
      prod_fall = hmv_pkg::PROD_W'(in_data.fall_num)
                * hmv_pkg::PROD_W'(hmv_pkg::RECIP_25);
      b_in.sector = in_data.sector;
      b_in.bad    = in_data.bad;
      if (in_data.fit) begin
         b_in.rise = prod_rise[hmv_pkg::RECIP_SHIFT +: 8];
         b_in.fall = prod_fall[hmv_pkg::RECIP_SHIFT +: 8];
      end else begin
         b_in.rise = in_data.rise_num[7:0];
         b_in.fall = in_data.fall_num[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      if (en && in_valid) begin
         b_ff <= b_in;
      end
   end

   assign out_valid = v_ff;
   assign out_data  = b_ff;

endmodule

`default_nettype wire

// ===== design/hmv_colour_out.sv =====
// Sector rule and output register: places the rising, falling, full and
// zero channels, or white for a bad value. Depends on hmv_pkg and the macros.
`default_nettype none
`include "heatmap_value_to_rgb_assert.svh"

module hmv_colour_out (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire hmv_pkg::bytes_type in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic [7:0]              red,
   output logic [7:0]              green,
   output logic [7:0]              blue,
   output logic                    out_of_range
);

   logic       en;
   logic       v_ff, v_in;
   logic [7:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic       oor_ff;

   assign en       = !v_ff || out_ready;
   assign in_ready = en;
   assign v_in     = en ? in_valid : v_ff;

   always_comb begin
      case (in_data.sector)
         hmv_pkg::SEC_RED: begin
            red_in = hmv_pkg::BYTE_MAX; green_in = in_data.rise; blue_in = 8'd0;
         end
         hmv_pkg::SEC_YELLOW: begin
            red_in = in_data.fall; green_in = hmv_pkg::BYTE_MAX; blue_in = 8'd0;
         end
         hmv_pkg::SEC_GREEN: begin
            red_in = 8'd0; green_in = hmv_pkg::BYTE_MAX; blue_in = in_data.rise;
         end
         hmv_pkg::SEC_CYAN: begin
            red_in = 8'd0; green_in = in_data.fall; blue_in = hmv_pkg::BYTE_MAX;
         end
         hmv_pkg::SEC_BLUE: begin
            red_in = in_data.rise; green_in = 8'd0; blue_in = hmv_pkg::BYTE_MAX;
         end
         default: begin
            red_in = hmv_pkg::BYTE_MAX; green_in = 8'd0; blue_in = in_data.fall;
         end
      endcase
      if (in_data.bad) begin
         red_in   = hmv_pkg::BYTE_MAX;
         green_in = hmv_pkg::BYTE_MAX;
         blue_in  = hmv_pkg::BYTE_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      if (en && in_valid) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         oor_ff   <= in_data.bad;
      end
   end

   assign out_valid    = v_ff;
   assign red          = red_ff;
   assign green        = green_ff;
   assign blue         = blue_ff;
   assign out_of_range = oor_ff;

   `HMV_ASSERT_IMP(a_out_white, clock, reset, v_ff && oor_ff,
      (red_ff == 8'd255) && (green_ff == 8'd255) && (blue_ff == 8'd255),
      "out-of-range response is not white")
   `HMV_ASSERT_IMP(a_out_full_channel, clock, reset, v_ff && !oor_ff,
      (red_ff == 8'd255) || (green_ff == 8'd255) || (blue_ff == 8'd255),
      "colour response has no full channel")

endmodule

`default_nettype wire

// ===== design/heatmap_value_to_rgb.sv =====
// Heat-map colour mapper top level: fitness-mode register and five stages.
// Requests pass the front stages, the scale stage and the output register, one
// per cycle unless rsp_chan stalls; stages advance independently and fill bubbles.
// Synchronous active-high reset empties the pipeline and clears fitness_mode to 0.
// Depends on hmv_pkg, hmv_channels, hmv_front, hmv_scale and hmv_colour_out.
`default_nettype none

module heatmap_value_to_rgb #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   hmv_csr_if.sink    csr_chan,
   hmv_req_if.sink    req_chan,
   hmv_rsp_if.source  rsp_chan
);

   logic                fitness_mode_ff, fitness_mode_in;
   logic                f_valid, f_ready, s_valid, s_ready;
   hmv_pkg::scaled_type f_data;
   hmv_pkg::bytes_type  s_data;

   assign csr_chan.ready = 1'b1;
   assign fitness_mode_in = csr_chan.valid ? csr_chan.fitness_mode : fitness_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fitness_mode_ff <= 1'b0;
      end else begin
         fitness_mode_ff <= fitness_mode_in;
      end
   end

   hmv_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_chan.valid),
      .in_ready     (req_chan.ready),
      .sample_value (req_chan.sample_value),
      .fitness_mode (fitness_mode_ff),
      .out_valid    (f_valid),
      .out_ready    (f_ready),
      .out_data     (f_data)
   );

   hmv_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (s_valid),
      .out_ready (s_ready),
      .out_data  (s_data)
   );

   hmv_colour_out u_out (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s_valid),
      .in_ready     (s_ready),
      .in_data      (s_data),
      .out_valid    (rsp_chan.valid),
      .out_ready    (rsp_chan.ready),
      .red          (rsp_chan.red),
      .green        (rsp_chan.green),
      .blue         (rsp_chan.blue),
      .out_of_range (rsp_chan.out_of_range)
   );

endmodule

`default_nettype wire
